>>> src/gte_pkg.sv
// shared types and constants for the gradient threshold edge map
// no dependencies; every other file but gte_line_store refers to this package by scoped names
`default_nettype none

package gte_pkg;

	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;
	localparam int COL_W    = 11;
	localparam int ROW_W    = 16;
	localparam int IMG_W_W  = 12;
	localparam int THRESH_W = 15;
	localparam int SQ_W     = 14;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int MIN_DIM = 3;

	localparam logic [IMG_W_W-1:0]  WIDTH_RST  = 12'd640;
	localparam logic [ROW_W-1:0]    HEIGHT_RST = 16'd480;
	localparam logic [THRESH_W-1:0] THRESH_RST = 15'd300;

	localparam logic [CHAN_W-1:0] EDGE_VAL = 8'd0;
	localparam logic [CHAN_W-1:0] FLAT_VAL = 8'd255;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pix_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic [COL_W-1:0]  center_col;
		logic [ROW_W-1:0]  center_row;
		logic              last_of_image;
	} res_t;

	// position info that travels with an item down the pipeline
	typedef struct packed {
		logic [COL_W-1:0] center_col;
		logic [ROW_W-1:0] center_row;
		logic             last_of_image;
	} pos_t;

endpackage

`default_nettype wire

>>> src/gte_line_store.sv
// two-row line store: one word per column holding the previous and older row
// one write port and one registered read port; uses no package items
`default_nettype none

module gte_line_store #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11,
	parameter int DATA_W = 48
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> src/gte_lane.sv
// one color channel: halved central differences, squares, threshold compare
// depends on gte_pkg for widths
`default_nettype none

module gte_lane (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [gte_pkg::CHAN_W-1:0]    px_right,
	input  wire logic [gte_pkg::CHAN_W-1:0]    px_left,
	input  wire logic [gte_pkg::CHAN_W-1:0]    px_below,
	input  wire logic [gte_pkg::CHAN_W-1:0]    px_above,
	input  wire logic [gte_pkg::THRESH_W-1:0]  thresh,
	output logic                               is_edge
);

	// difference halved with truncation toward zero
	function automatic logic signed [7:0] half_diff(input logic [7:0] a, input logic [7:0] b);
		logic signed [8:0] d;
		logic signed [8:0] t;
		d = $signed({1'b0, a}) - $signed({1'b0, b});
		t = d + $signed({8'd0, d[8]});
		return t[8:1];
	endfunction

	logic signed [7:0]  hx, hy;
	logic signed [15:0] px, py;
	logic [gte_pkg::SQ_W-1:0]     sqx_s2, sqy_s2;
	logic [gte_pkg::THRESH_W-1:0] norm;

	assign hx = half_diff(px_right, px_left);
	assign hy = half_diff(px_below, px_above);
	assign px = hx * hx;
	assign py = hy * hy;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= px[gte_pkg::SQ_W-1:0];
			sqy_s2 <= py[gte_pkg::SQ_W-1:0];
		end
	end

	assign norm    = gte_pkg::THRESH_W'(sqx_s2) + gte_pkg::THRESH_W'(sqy_s2);
	assign is_edge = norm > thresh;

endmodule

`default_nettype wire

>>> src/gte_merge.sv
// output stage: merges the three lane decisions with the position into an item
// depends on gte_pkg for the result and position types
`default_nettype none

module gte_merge (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic [gte_pkg::NUM_CHAN-1:0]   lane_edge,
	input  wire gte_pkg::pos_t                  pos,
	output logic                                res_valid,
	output gte_pkg::res_t                       res
);

	logic          valid_q;
	gte_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			res_q.red_out       <= lane_edge[0] ? gte_pkg::EDGE_VAL : gte_pkg::FLAT_VAL;
			res_q.green_out     <= lane_edge[1] ? gte_pkg::EDGE_VAL : gte_pkg::FLAT_VAL;
			res_q.blue_out      <= lane_edge[2] ? gte_pkg::EDGE_VAL : gte_pkg::FLAT_VAL;
			res_q.center_col    <= pos.center_col;
			res_q.center_row    <= pos.center_row;
			res_q.last_of_image <= pos.last_of_image;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> src/gradient_threshold_edge_map.sv
// gradient threshold edge map, top level
// depends on gte_pkg, gte_line_store, gte_lane and gte_merge
//
// Takes RGB pixels in raster order, one item per clock, and for every interior
// pixel gives one item carrying three channel decisions: 0 where
// (dx/2)^2 + (dy/2)^2 of the central differences exceeds edge_threshold, 255
// otherwise. Pixels in the first or last row or column give no item. A result
// for center (r-1, c-1) passes the stage 1, stage 2 and output registers after
// pixel (r, c) is taken; the input takes a new pixel every cycle unless stalled.
// A held result stops the whole pipeline, and that stall reaches the input in
// the same cycle. The single two-row line store keeps up with one item per
// cycle (one read and one write per cycle, one 48-bit word per column). Width
// in use is image_width clamped to [3, MAX_WIDTH], height is image_height
// raised to at least 3; counters wrap at row and image ends. Write
// configuration only while the block is idle.
// The line store holds no reset; after a width increase mid-image the first
// new columns read stale data.
`default_nettype none

module gradient_threshold_edge_map #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// pixel input channel
	input  wire logic                                pix_valid,
	output logic                                     pix_stall,
	input  wire gte_pkg::pix_t                       pix,
	// result output channel
	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output gte_pkg::res_t                            res,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [gte_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [gte_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	// compare width for columns, wide enough for the register and MAX_WIDTH
	localparam int WW = (CW + 1 > gte_pkg::IMG_W_W) ? CW + 1 : gte_pkg::IMG_W_W;
	localparam int PW = $bits(gte_pkg::pix_t);
	localparam int RW = gte_pkg::ROW_W;

	// configuration registers
	logic [gte_pkg::IMG_W_W-1:0]  width_q;
	logic [RW-1:0]                height_q;
	logic [gte_pkg::THRESH_W-1:0] thresh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gte_pkg::WIDTH_RST;
			height_q <= gte_pkg::HEIGHT_RST;
			thresh_q <= gte_pkg::THRESH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gte_pkg::CFG_IMAGE_WIDTH: begin
					width_q <= cfg_data[gte_pkg::IMG_W_W-1:0];
				end
				gte_pkg::CFG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[RW-1:0];
				end
				gte_pkg::CFG_EDGE_THRESHOLD: begin
					thresh_q <= cfg_data[gte_pkg::THRESH_W-1:0];
				end
				default: begin
					// unmapped index, ignored
				end
			endcase
		end
	end

	// effective image size
	logic [WW-1:0] w_raw, w_eff;
	logic [RW-1:0] h_eff;

	assign w_raw = WW'(width_q);
	always_comb begin
		if (w_raw < WW'(gte_pkg::MIN_DIM)) begin
			w_eff = WW'(gte_pkg::MIN_DIM);
		end else if (w_raw > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
	end
	assign h_eff = (height_q < RW'(gte_pkg::MIN_DIM)) ? RW'(gte_pkg::MIN_DIM) : height_q;

	// the whole pipeline moves unless a finished result is held
	logic adv, accept;
	assign adv       = !(res_valid && res_stall);
	assign pix_stall = !adv;
	assign accept    = pix_valid && adv;

	// position counters of the arriving pixel
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] col_nx;
	logic [RW:0]   row_nx;
	logic          col_end, row_end, has_res;
	gte_pkg::pos_t pos0;

	assign col_nx  = WW'(col_q) + WW'(1);
	assign row_nx  = {1'b0, row_q} + (RW+1)'(1);
	assign col_end = col_nx >= w_eff;
	assign row_end = row_nx >= {1'b0, h_eff};
	assign has_res = (row_q >= RW'(2)) && (col_q >= CW'(2));

	assign pos0.center_col    = gte_pkg::COL_W'(col_q - CW'(1));
	assign pos0.center_row    = row_q - RW'(1);
	assign pos0.last_of_image = row_end && col_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_nx[RW-1:0];
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: line store data arrives, window shifts, lanes square
	logic          v_s1, res_s1;
	gte_pkg::pos_t pos_s1;
	logic [CW-1:0] col_s1;
	gte_pkg::pix_t cur_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			res_s1 <= 1'b0;
		end else if (adv) begin
			v_s1   <= accept;
			res_s1 <= accept && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos0;
			col_s1 <= col_q;
			cur_s1 <= pix;
		end
	end

	// store word: upper half previous row, lower half row before it
	logic [2*PW-1:0] rd_word;
	gte_pkg::pix_t   prev_here, older_here;
	logic            st_we;

	assign prev_here  = rd_word[2*PW-1:PW];
	assign older_here = rd_word[PW-1:0];
	assign st_we      = v_s1 && adv;

	gte_line_store #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (CW),
		.DATA_W (2*PW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (col_s1),
		.wdata ({cur_s1, prev_here}),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_word)
	);

	// short window: previous row at c-1 and c-2, older row at c-1, current at c-1
	gte_pkg::pix_t mid0_q, mid1_q, above_q, left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid0_q  <= '0;
			mid1_q  <= '0;
			above_q <= '0;
			left_q  <= '0;
		end else if (st_we) begin
			mid1_q  <= mid0_q;
			mid0_q  <= prev_here;
			above_q <= older_here;
			left_q  <= cur_s1;
		end
	end

	// one lane per color channel, red is lane 0
	logic [gte_pkg::NUM_CHAN-1:0] lane_edge;

	for (genvar k = 0; k < gte_pkg::NUM_CHAN; k++) begin : g_lane
		localparam int HI = PW - 1 - k * gte_pkg::CHAN_W;
		gte_lane u_lane (
			.clk      (clk),
			.en       (adv),
			.px_right (prev_here[HI -: gte_pkg::CHAN_W]),
			.px_left  (mid1_q[HI -: gte_pkg::CHAN_W]),
			.px_below (left_q[HI -: gte_pkg::CHAN_W]),
			.px_above (above_q[HI -: gte_pkg::CHAN_W]),
			.thresh   (thresh_q),
			.is_edge  (lane_edge[k])
		);
	end

	// stage 2: lanes compare, position follows
	logic          res_s2;
	gte_pkg::pos_t pos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else if (adv) begin
			res_s2 <= res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s2 <= pos_s1;
		end
	end

	// output register
	gte_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (res_s2),
		.lane_edge (lane_edge),
		.pos       (pos_s2),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

`default_nettype wire
